@@ sv/gpct_pkg.sv @@
// ----------------------------------------------------------------------------
// gpct_pkg
// Shared types and constants for the grace period callback tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package gpct_pkg;

  // item operation codes, carried on in_tuser
  typedef enum logic [1:0] {
    OP_REPORT = 2'd0,
    OP_TICK   = 2'd1,
    OP_ENQ    = 2'd2,
    OP_DRAIN  = 2'd3
  } op_t;

  // result kinds, carried on out_tuser
  localparam logic KIND_READY = 1'b0;
  localparam logic KIND_FULL  = 1'b1;

  // field widths
  localparam int HANDLE_W = 16;
  localparam int COUNT_W  = 32;
  localparam int MASK_W   = 8;
  localparam int ID_W     = 3;

  // a drain releases at most this many handles
  localparam int MAX_RESULTS = 32;
  localparam int RES_CW      = 6;

  // wide enough for any processor index in range
  localparam int CPU_XW = 7;

endpackage

`default_nettype wire

@@ sv/gpct_ram.sv @@
// ----------------------------------------------------------------------------
// gpct_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module gpct_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  wire logic                                      clk,
  input  wire logic                                      wr_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                          wr_data,
  input  wire logic                                      rd_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                          rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // registered read, holds when not enabled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ sv/grace_period_callback_tracker_unit.sv @@
// ----------------------------------------------------------------------------
// grace_period_callback_tracker_unit
// Quiescent-state grace period tracker with a table of deferred handles.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  channel: one item per handshake; in_tuser is the operation
//     (report, tick, enqueue, drain), in_tdata carries processor, masks
//     and handle. An item is taken when in_tvalid and in_tready are high.
//   out_* channel: result items; out_tuser is the kind (ready or refused),
//     out_tlast marks the final result of an input item.
//   Steps per item: an enqueue is stored at once, or its result goes to
//     the output register; a report reads, then writes its counter entry;
//     a tick with work reads, then evaluates and writes, each counter
//     entry; a drain with work reads and evaluates each slot in a counting
//     pass, then in an emitting pass that stops after the last release.
//   A single access to each memory is in flight at a time, so every
//   read-modify-write finishes before the next read of any entry.
//   Results leave through one output register; the block takes the next
//   item while a finished result waits there. When the receiver stalls,
//   an item with further results waits in place with in_tready low.
//   Reset (rst_n low, synchronous) clears all counters, the period state
//   and the valid bits of both memories; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module grace_period_callback_tracker_unit
  import gpct_pkg::*;
#(
  parameter int CPU_COUNT   = 8,
  parameter int TABLE_DEPTH = 32
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  // input items
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [39:0]  in_tdata,   // cpu, running_mask, idle_mask, callback_handle
  input  wire logic [1:0]   in_tuser,   // operation
  // result items
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic      [111:0] out_tdata,  // ready_handle, periods_done, queued_count,
                                        // retired_count
  output logic      [0:0]   out_tuser,  // result_kind
  output logic              out_tlast
);

  localparam int CW  = $clog2(CPU_COUNT);
  localparam int SW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CRW = 2 * COUNT_W;
  localparam int SRW = COUNT_W + HANDLE_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CPU_RD,
    S_CPU_EX,
    S_ENQ_OUT,
    S_DR1_RD,
    S_DR1_EX,
    S_DR2_RD,
    S_DR2_EX
  } state_t;

  // input field split
  logic                in_fire;
  op_t                 in_op;
  logic [ID_W-1:0]     in_cpu;
  logic [MASK_W-1:0]   in_running;
  logic [MASK_W-1:0]   in_idle;
  logic [HANDLE_W-1:0] in_handle;

  assign in_fire    = in_tvalid && in_tready;
  assign in_op      = op_t'(in_tuser);
  assign in_cpu     = in_tdata[2:0];
  assign in_running = in_tdata[10:3];
  assign in_idle    = in_tdata[18:11];
  assign in_handle  = in_tdata[34:19];

  // registers
  state_t               state_r, state_nxt;
  logic [COUNT_W-1:0]   periods_r, periods_nxt;
  logic                 in_flight_r, in_flight_nxt;
  logic [COUNT_W-1:0]   drained_at_r, drained_at_nxt;
  logic [COUNT_W-1:0]   deferred_r, deferred_nxt;
  logic [COUNT_W-1:0]   released_r, released_nxt;
  logic [TABLE_DEPTH-1:0] slot_valid_r, slot_valid_nxt;
  logic [CPU_COUNT-1:0] cpu_init_r, cpu_init_nxt;
  logic                 tick_start_r, tick_start_nxt;
  logic                 blocked_r, blocked_nxt;
  logic [ID_W-1:0]      me_r, me_nxt;
  logic [MASK_W-1:0]    run_r, run_nxt;
  logic [MASK_W-1:0]    idle_r, idle_nxt;
  logic                 is_report_r, is_report_nxt;
  logic [CW-1:0]        cidx_r, cidx_nxt;
  logic [SW-1:0]        sidx_r, sidx_nxt;
  logic [RES_CW-1:0]    cnt_r, cnt_nxt;
  logic [RES_CW-1:0]    em_r, em_nxt;
  logic [HANDLE_W-1:0]  pend_handle_r, pend_handle_nxt;
  logic                 pend_kind_r, pend_kind_nxt;
  // output register
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_kind_r, out_kind_nxt;
  logic                 out_last_r, out_last_nxt;
  logic [HANDLE_W-1:0]  out_handle_r, out_handle_nxt;
  logic [COUNT_W-1:0]   out_periods_r, out_periods_nxt;
  logic [COUNT_W-1:0]   out_queued_r, out_queued_nxt;
  logic [COUNT_W-1:0]   out_retired_r, out_retired_nxt;

  // memory ports
  logic                 cram_we;
  logic [CRW-1:0]       cram_wdata;
  logic                 cram_re;
  logic [CRW-1:0]       cram_rdata;
  logic                 sram_we;
  logic [SW-1:0]        sram_waddr;
  logic [SRW-1:0]       sram_wdata;
  logic                 sram_re;
  logic [SRW-1:0]       sram_rdata;

  // counter and snapshot per processor: {snapshot, counter}
  gpct_ram #(
    .WIDTH (CRW),
    .DEPTH (CPU_COUNT)
  ) u_cpu_ram (
    .clk     (clk),
    .wr_en   (cram_we),
    .wr_addr (cidx_r),
    .wr_data (cram_wdata),
    .rd_en   (cram_re),
    .rd_addr (cidx_r),
    .rd_data (cram_rdata)
  );

  // deferred handles: {stamp, handle}
  gpct_ram #(
    .WIDTH (SRW),
    .DEPTH (TABLE_DEPTH)
  ) u_slot_ram (
    .clk     (clk),
    .wr_en   (sram_we),
    .wr_addr (sram_waddr),
    .wr_data (sram_wdata),
    .rd_en   (sram_re),
    .rd_addr (sidx_r),
    .rd_data (sram_rdata)
  );

  // entries never written read as zero
  logic [COUNT_W-1:0] cur_cnt;
  logic [COUNT_W-1:0] cur_snap;
  assign cur_cnt  = cpu_init_r[cidx_r] ? cram_rdata[COUNT_W-1:0] : '0;
  assign cur_snap = cpu_init_r[cidx_r] ? cram_rdata[CRW-1:COUNT_W] : '0;

  // processor under sweep: mask bits exist only below eight
  logic [CPU_XW-1:0] cidx_ext;
  logic              cur_busy;
  assign cidx_ext = CPU_XW'(cidx_r);
  assign cur_busy = (cidx_ext < CPU_XW'(MASK_W)) && run_r[cidx_ext[2:0]] &&
                    !idle_r[cidx_ext[2:0]] &&
                    (cidx_ext != CPU_XW'(me_r)) && (cur_cnt == cur_snap);

  logic cpu_last;
  logic slot_last;
  assign cpu_last  = (cidx_r == CW'(CPU_COUNT - 1));
  assign slot_last = (sidx_r == SW'(TABLE_DEPTH - 1));

  // slot under sweep ready for release
  logic slot_ready;
  assign slot_ready = slot_valid_r[sidx_r] &&
                      (sram_rdata[SRW-1:HANDLE_W] <= periods_r);

  // lowest free slot
  logic          free_found;
  logic [SW-1:0] free_idx;
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
      if (!slot_valid_r[i]) begin
        free_found = 1'b1;
        free_idx   = SW'(i);
      end
    end
  end

  // some other in-range processor running
  logic other_running;
  always_comb begin
    other_running = 1'b0;
    for (int c = 0; c < MASK_W; c++) begin
      if ((c < CPU_COUNT) && (ID_W'(c) != in_cpu) && in_running[c]) begin
        other_running = 1'b1;
      end
    end
  end

  logic any_valid;
  logic out_free;
  logic cpu_in_range;
  assign any_valid    = |slot_valid_r;
  assign out_free     = !out_valid_r || out_tready;
  assign cpu_in_range = (CPU_XW'(in_cpu) < CPU_XW'(CPU_COUNT));

  assign in_tready = (state_r == S_IDLE);

  // next-state logic
  always_comb begin
    state_nxt       = state_r;
    periods_nxt     = periods_r;
    in_flight_nxt   = in_flight_r;
    drained_at_nxt  = drained_at_r;
    deferred_nxt    = deferred_r;
    released_nxt    = released_r;
    slot_valid_nxt  = slot_valid_r;
    cpu_init_nxt    = cpu_init_r;
    tick_start_nxt  = tick_start_r;
    blocked_nxt     = blocked_r;
    me_nxt          = me_r;
    run_nxt         = run_r;
    idle_nxt        = idle_r;
    is_report_nxt   = is_report_r;
    cidx_nxt        = cidx_r;
    sidx_nxt        = sidx_r;
    cnt_nxt         = cnt_r;
    em_nxt          = em_r;
    pend_handle_nxt = pend_handle_r;
    pend_kind_nxt   = pend_kind_r;
    out_valid_nxt   = out_valid_r && !out_tready;
    out_kind_nxt    = out_kind_r;
    out_last_nxt    = out_last_r;
    out_handle_nxt  = out_handle_r;
    out_periods_nxt = out_periods_r;
    out_queued_nxt  = out_queued_r;
    out_retired_nxt = out_retired_r;
    cram_we         = 1'b0;
    cram_wdata      = {cur_snap, cur_cnt};
    cram_re         = 1'b0;
    sram_we         = 1'b0;
    sram_waddr      = free_idx;
    sram_wdata      = {periods_r + (in_flight_r ? COUNT_W'(2) : COUNT_W'(1)), in_handle};
    sram_re         = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          me_nxt   = in_cpu;
          run_nxt  = in_running;
          idle_nxt = in_idle;
          case (in_op)
            OP_REPORT: begin
              if (cpu_in_range) begin
                is_report_nxt = 1'b1;
                cidx_nxt      = CW'(in_cpu);
                state_nxt     = S_CPU_RD;
              end
            end
            OP_TICK: begin
              if (any_valid || in_flight_r) begin
                is_report_nxt  = 1'b0;
                tick_start_nxt = !in_flight_r;
                blocked_nxt    = 1'b0;
                cidx_nxt       = '0;
                state_nxt      = S_CPU_RD;
              end
            end
            OP_ENQ: begin
              if (!other_running) begin
                pend_kind_nxt   = KIND_READY;
                pend_handle_nxt = in_handle;
                state_nxt       = S_ENQ_OUT;
              end else if (free_found) begin
                sram_we                  = 1'b1;
                slot_valid_nxt[free_idx] = 1'b1;
                deferred_nxt             = deferred_r + COUNT_W'(1);
              end else begin
                pend_kind_nxt   = KIND_FULL;
                pend_handle_nxt = in_handle;
                state_nxt       = S_ENQ_OUT;
              end
            end
            OP_DRAIN: begin
              if (any_valid && (periods_r != drained_at_r)) begin
                drained_at_nxt = periods_r;
                sidx_nxt       = '0;
                cnt_nxt        = '0;
                state_nxt      = S_DR1_RD;
              end
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end

      S_CPU_RD: begin
        cram_re   = 1'b1;
        state_nxt = S_CPU_EX;
      end

      // counter entry in hand: bump, snapshot or check
      S_CPU_EX: begin
        if (is_report_r) begin
          cram_we              = 1'b1;
          cram_wdata           = {cur_snap, cur_cnt + COUNT_W'(1)};
          cpu_init_nxt[cidx_r] = 1'b1;
          state_nxt            = S_IDLE;
        end else if (tick_start_r) begin
          cram_we              = 1'b1;
          cram_wdata           = {cur_cnt, cur_cnt};
          cpu_init_nxt[cidx_r] = 1'b1;
          if (cpu_last) begin
            in_flight_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end else begin
            cidx_nxt  = cidx_r + CW'(1);
            state_nxt = S_CPU_RD;
          end
        end else begin
          blocked_nxt = blocked_r || cur_busy;
          if (cpu_last) begin
            if (!(blocked_r || cur_busy)) begin
              periods_nxt   = periods_r + COUNT_W'(1);
              in_flight_nxt = 1'b0;
            end
            state_nxt = S_IDLE;
          end else begin
            cidx_nxt  = cidx_r + CW'(1);
            state_nxt = S_CPU_RD;
          end
        end
      end

      // single result of an enqueue
      S_ENQ_OUT: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_kind_nxt    = pend_kind_r;
          out_handle_nxt  = pend_handle_r;
          out_last_nxt    = 1'b1;
          out_periods_nxt = periods_r;
          out_queued_nxt  = deferred_r;
          out_retired_nxt = released_r;
          state_nxt       = S_IDLE;
        end
      end

      S_DR1_RD: begin
        sram_re   = 1'b1;
        state_nxt = S_DR1_EX;
      end

      // counting pass: results must carry the final release count
      S_DR1_EX: begin
        if (slot_ready && (cnt_r != RES_CW'(MAX_RESULTS))) begin
          cnt_nxt = cnt_r + RES_CW'(1);
        end
        if (slot_last) begin
          released_nxt = released_r + COUNT_W'(cnt_nxt);
          sidx_nxt     = '0;
          em_nxt       = '0;
          state_nxt    = (cnt_nxt == '0) ? S_IDLE : S_DR2_RD;
        end else begin
          sidx_nxt  = sidx_r + SW'(1);
          state_nxt = S_DR1_RD;
        end
      end

      S_DR2_RD: begin
        sram_re   = 1'b1;
        state_nxt = S_DR2_EX;
      end

      // emitting pass, waits on the output register
      S_DR2_EX: begin
        if (slot_ready) begin
          if (out_free) begin
            out_valid_nxt          = 1'b1;
            out_kind_nxt           = KIND_READY;
            out_handle_nxt         = sram_rdata[HANDLE_W-1:0];
            out_last_nxt           = (em_r + RES_CW'(1) == cnt_r);
            out_periods_nxt        = periods_r;
            out_queued_nxt         = deferred_r;
            out_retired_nxt        = released_r;
            slot_valid_nxt[sidx_r] = 1'b0;
            em_nxt                 = em_r + RES_CW'(1);
            if ((em_r + RES_CW'(1) == cnt_r) || slot_last) begin
              state_nxt = S_IDLE;
            end else begin
              sidx_nxt  = sidx_r + SW'(1);
              state_nxt = S_DR2_RD;
            end
          end
        end else if (slot_last) begin
          state_nxt = S_IDLE;
        end else begin
          sidx_nxt  = sidx_r + SW'(1);
          state_nxt = S_DR2_RD;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      periods_r     <= '0;
      in_flight_r   <= 1'b0;
      drained_at_r  <= '0;
      deferred_r    <= '0;
      released_r    <= '0;
      slot_valid_r  <= '0;
      cpu_init_r    <= '0;
      tick_start_r  <= 1'b0;
      blocked_r     <= 1'b0;
      is_report_r   <= 1'b0;
      cidx_r        <= '0;
      sidx_r        <= '0;
      cnt_r         <= '0;
      em_r          <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      periods_r     <= periods_nxt;
      in_flight_r   <= in_flight_nxt;
      drained_at_r  <= drained_at_nxt;
      deferred_r    <= deferred_nxt;
      released_r    <= released_nxt;
      slot_valid_r  <= slot_valid_nxt;
      cpu_init_r    <= cpu_init_nxt;
      tick_start_r  <= tick_start_nxt;
      blocked_r     <= blocked_nxt;
      is_report_r   <= is_report_nxt;
      cidx_r        <= cidx_nxt;
      sidx_r        <= sidx_nxt;
      cnt_r         <= cnt_nxt;
      em_r          <= em_nxt;
      out_valid_r   <= out_valid_nxt;
    end
    me_r          <= me_nxt;
    run_r         <= run_nxt;
    idle_r        <= idle_nxt;
    pend_handle_r <= pend_handle_nxt;
    pend_kind_r   <= pend_kind_nxt;
    out_kind_r    <= out_kind_nxt;
    out_last_r    <= out_last_nxt;
    out_handle_r  <= out_handle_nxt;
    out_periods_r <= out_periods_nxt;
    out_queued_r  <= out_queued_nxt;
    out_retired_r <= out_retired_nxt;
  end

  // output port packing
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {out_retired_r, out_queued_r, out_periods_r, out_handle_r};

`ifndef ASSERT_OFF
  // release count never exceeds the per-drain limit
  assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= RES_CW'(MAX_RESULTS))
    else $error("drain count above limit");

  // emitting pass never runs past the counted releases
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DR2_RD || state_r == S_DR2_EX) |-> (em_r < cnt_r))
    else $error("drain emitted more than counted");

  // release total moves only at the end of a counting pass
  assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(released_r) |-> $past(state_r == S_DR1_EX))
    else $error("release total changed outside drain");

  // at most one slot fills per cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    $countones(slot_valid_r) <= $past($countones(slot_valid_r)) + 1)
    else $error("more than one slot filled in a cycle");

  // a period completes only from a tick sweep
  assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(periods_r) |-> ($past(state_r == S_CPU_EX) && $fell(in_flight_r)))
    else $error("period count changed outside tick");
`endif

endmodule

`default_nettype wire

@@ dv/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the grace period callback tracker. Random and
// directed report, tick, enqueue and drain items go into the input stream;
// a scoreboard class predicts every released, handed-back or refused
// handle and checks the result stream field by field.
// ----------------------------------------------------------------------------

module tb;
  import gpct_pkg::*;

  localparam int NCPU      = 8;
  localparam int NSLOT     = 32;
  localparam int LIMIT     = 2000000;
  localparam int SETTLE    = 200;
  localparam int PER_PHASE = 85;

  // one result item as the block should present it
  typedef struct packed {
    logic                kind;
    logic [HANDLE_W-1:0] handle;
    logic                is_last;
    logic [COUNT_W-1:0]  periods;
    logic [COUNT_W-1:0]  queued;
    logic [COUNT_W-1:0]  retired;
  } release_t;

  // predicts the tracker and holds the results still owed by the block
  class gp_tracker_sb;
    logic [COUNT_W-1:0]  qs_count [NCPU];
    logic [COUNT_W-1:0]  snap [NCPU];
    logic [COUNT_W-1:0]  periods;
    logic                in_flight;
    logic [COUNT_W-1:0]  drained_at;
    logic                slot_used [NSLOT];
    logic [HANDLE_W-1:0] slot_handle [NSLOT];
    logic [COUNT_W-1:0]  slot_stamp [NSLOT];
    logic [COUNT_W-1:0]  deferred;
    logic [COUNT_W-1:0]  released;
    release_t            owed_q [$];
    int                  errors;
    int                  n_handback;
    int                  n_refused;
    int                  n_released;
    int                  biggest_drain;

    function new();
      for (int c = 0; c < NCPU; c++) begin
        qs_count[c] = '0;
        snap[c]     = '0;
      end
      for (int s = 0; s < NSLOT; s++) begin
        slot_used[s]   = 1'b0;
        slot_handle[s] = '0;
        slot_stamp[s]  = '0;
      end
      periods       = '0;
      in_flight     = 1'b0;
      drained_at    = '0;
      deferred      = '0;
      released      = '0;
      errors        = 0;
      n_handback    = 0;
      n_refused     = 0;
      n_released    = 0;
      biggest_drain = 0;
    endfunction

    function int pending();
      return owed_q.size();
    endfunction

    function bit table_busy();
      for (int s = 0; s < NSLOT; s++)
        if (slot_used[s]) return 1'b1;
      return 1'b0;
    endfunction

    function void owe(logic kind, logic [HANDLE_W-1:0] h);
      release_t r;
      r.kind    = kind;
      r.handle  = h;
      r.is_last = 1'b1;
      r.periods = periods;
      r.queued  = deferred;
      r.retired = released;
      owed_q.push_back(r);
    endfunction

    // tick: open a period, or close it once every other busy processor reported
    function void tick(logic [ID_W-1:0] cpu, logic [MASK_W-1:0] run,
                       logic [MASK_W-1:0] idle);
      if (!table_busy() && !in_flight) return;
      if (!in_flight) begin
        for (int c = 0; c < NCPU; c++) snap[c] = qs_count[c];
        in_flight = 1'b1;
        return;
      end
      for (int c = 0; c < NCPU; c++)
        if (c != cpu && run[c] && !idle[c] && qs_count[c] == snap[c]) return;
      periods   = periods + 1;
      in_flight = 1'b0;
    endfunction

    function void enqueue(logic [ID_W-1:0] cpu, logic [MASK_W-1:0] run,
                          logic [HANDLE_W-1:0] h);
      logic [MASK_W-1:0] others;
      others = run & ~(MASK_W'(1) << cpu);
      // nobody else running: handed straight back
      if (others == '0) begin
        owe(KIND_READY, h);
        n_handback++;
        return;
      end
      for (int s = 0; s < NSLOT; s++) begin
        if (!slot_used[s]) begin
          slot_used[s]   = 1'b1;
          slot_handle[s] = h;
          slot_stamp[s]  = periods + (in_flight ? 32'd2 : 32'd1);
          deferred       = deferred + 1;
          return;
        end
      end
      owe(KIND_FULL, h);
      n_refused++;
    endfunction

    // drain: release every stamped-ready handle in slot order
    function void drain();
      int first;
      int n;
      first = owed_q.size();
      n     = 0;
      if (!table_busy() || periods == drained_at) return;
      drained_at = periods;
      for (int s = 0; s < NSLOT && n < MAX_RESULTS; s++) begin
        if (slot_used[s] && slot_stamp[s] <= periods) begin
          slot_used[s] = 1'b0;
          released     = released + 1;
          owe(KIND_READY, slot_handle[s]);
          n++;
        end
      end
      for (int k = 0; k < n; k++) begin
        owed_q[first + k].retired = released;
        owed_q[first + k].is_last = (k == n - 1);
      end
      n_released += n;
      if (n > biggest_drain) biggest_drain = n;
    endfunction

    function void note_item(op_t op, logic [ID_W-1:0] cpu, logic [MASK_W-1:0] run,
                            logic [MASK_W-1:0] idle, logic [HANDLE_W-1:0] h);
      case (op)
        OP_REPORT: qs_count[cpu] = qs_count[cpu] + 1;
        OP_TICK:   tick(cpu, run, idle);
        OP_ENQ:    enqueue(cpu, run, h);
        default:   drain();
      endcase
    endfunction

    function void check_result(logic kind, logic [HANDLE_W-1:0] h, logic is_last,
                               logic [COUNT_W-1:0] p, logic [COUNT_W-1:0] q,
                               logic [COUNT_W-1:0] r);
      release_t e;
      if (owed_q.size() == 0) begin
        $error("unexpected result item: kind %0d handle %0h", kind, h);
        errors++;
        return;
      end
      e = owed_q.pop_front();
      if (kind !== e.kind) begin
        $error("result_kind: expected %0h, got %0h", e.kind, kind);
        errors++;
      end
      if (h !== e.handle) begin
        $error("ready_handle: expected %0h, got %0h", e.handle, h);
        errors++;
      end
      if (is_last !== e.is_last) begin
        $error("last: expected %0h, got %0h", e.is_last, is_last);
        errors++;
      end
      if (p !== e.periods) begin
        $error("periods_done: expected %0h, got %0h", e.periods, p);
        errors++;
      end
      if (q !== e.queued) begin
        $error("queued_count: expected %0h, got %0h", e.queued, q);
        errors++;
      end
      if (r !== e.retired) begin
        $error("retired_count: expected %0h, got %0h", e.retired, r);
        errors++;
      end
    endfunction
  endclass

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_tvalid = 1'b0;
  logic          in_tready;
  logic [39:0]   in_tdata = '0;   // cpu, running_mask, idle_mask, callback_handle
  logic [1:0]    in_tuser = OP_REPORT;   // operation
  logic          out_tvalid;
  logic          out_tready = 1'b0;
  logic [111:0]  out_tdata;       // ready_handle, periods_done, queued_count,
                                  // retired_count
  logic [0:0]    out_tuser;       // result_kind
  logic          out_tlast;

  gp_tracker_sb  sb = new();
  int            idle_mode = 0;   // 0 none, 1 sender, 2 receiver, 3 both
  int            cycles = 0;
  int            sent = 0;
  int            op_seen [4] = '{0, 0, 0, 0};

  grace_period_callback_tracker_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // clock, period 4
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, sb.pending());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // receiver back-pressure
  always @(negedge clk) begin
    case (idle_mode)
      2:       out_tready <= ($urandom_range(0, 99) >= 85);
      3:       out_tready <= ($urandom_range(0, 99) >= 11);
      default: out_tready <= 1'b1;
    endcase
  end

  // check every accepted result item
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_result(out_tuser[0], out_tdata[15:0], out_tlast, out_tdata[47:16],
                      out_tdata[79:48], out_tdata[111:80]);
  end

  function automatic bit sender_gap();
    if (idle_mode == 1) return ($urandom_range(0, 99) < 85);
    if (idle_mode == 3) return ($urandom_range(0, 99) < 11);
    return 1'b0;
  endfunction

  function automatic logic [MASK_W-1:0] pick_mask();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      default: return MASK_W'($urandom);
    endcase
  endfunction

  function automatic logic [HANDLE_W-1:0] pick_handle();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return HANDLE_W'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic send_item(op_t op, logic [ID_W-1:0] cpu, logic [MASK_W-1:0] run,
                           logic [MASK_W-1:0] idle, logic [HANDLE_W-1:0] h);
    @(negedge clk);
    while (sender_gap()) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {5'b0, h, idle, run, cpu};
    do @(posedge clk); while (!in_tready);
    sb.note_item(op, cpu, run, idle, h);
    op_seen[op]++;
    sent++;
  endtask

  // hold the input quiet until every owed result is out and the block settled
  task automatic hold_until_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // a full grace period: open, reports, close attempts, drain
  task automatic period_round();
    logic [ID_W-1:0] me;
    me = ID_W'($urandom);
    send_item(OP_TICK, me, pick_mask(), pick_mask(), pick_handle());
    repeat ($urandom_range(2, 10))
      send_item(OP_REPORT, ID_W'($urandom), pick_mask(), pick_mask(), pick_handle());
    repeat ($urandom_range(1, 2))
      send_item(OP_TICK, me, pick_mask(), pick_mask(), pick_handle());
    send_item(OP_DRAIN, ID_W'($urandom), pick_mask(), pick_mask(), pick_handle());
  endtask

  // a run of enqueues from one processor with others running
  task automatic enqueue_burst(int n);
    logic [ID_W-1:0]   me;
    logic [MASK_W-1:0] run;
    me = ID_W'($urandom);
    for (int k = 0; k < n; k++) begin
      run = pick_mask() | (MASK_W'(1) << ((me + 1) % NCPU));
      send_item(OP_ENQ, me, run, pick_mask(), pick_handle());
    end
  endtask

  task automatic random_items(int n);
    int stop_at;
    int pick;
    stop_at = sent + n;
    while (sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 8)
        enqueue_burst($urandom_range(10, 36));
      else if (pick < 30)
        period_round();
      else if (pick < 55)
        enqueue_burst($urandom_range(1, 4));
      else
        send_item(op_t'($urandom_range(0, 3)), ID_W'($urandom), pick_mask(), pick_mask(),
                  pick_handle());
    end
  endtask

  initial begin
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // directed: empty table, hand-back, stamping, blocked and closing ticks
    send_item(OP_TICK, 3'd0, 8'hFF, 8'h00, 16'h0000);
    send_item(OP_DRAIN, 3'd0, 8'hFF, 8'h00, 16'h0000);
    send_item(OP_ENQ, 3'd3, 8'h08, 8'h00, 16'hFFFF);
    send_item(OP_ENQ, 3'd0, 8'h00, 8'hFF, 16'h0000);
    send_item(OP_ENQ, 3'd7, 8'hFF, 8'h00, 16'h0000);
    send_item(OP_ENQ, 3'd0, 8'h80, 8'h00, 16'hA5A5);
    send_item(OP_TICK, 3'd0, 8'hFF, 8'h00, 16'h1234);
    send_item(OP_ENQ, 3'd1, 8'hFF, 8'hFF, 16'h5A5A);
    send_item(OP_TICK, 3'd0, 8'hFF, 8'h00, 16'h0000);
    for (int c = 1; c < NCPU; c++)
      send_item(OP_REPORT, ID_W'(c), 8'h00, 8'h00, 16'hFFFF);
    send_item(OP_TICK, 3'd0, 8'hFF, 8'h00, 16'h0000);
    send_item(OP_DRAIN, 3'd2, 8'h00, 8'hFF, 16'h0000);
    send_item(OP_DRAIN, 3'd2, 8'h00, 8'hFF, 16'h0000);
    send_item(OP_REPORT, 3'd0, 8'hFF, 8'hFF, 16'hFFFF);
    send_item(OP_TICK, 3'd7, 8'h7F, 8'hFF, 16'h0000);
    send_item(OP_TICK, 3'd7, 8'h7F, 8'h7F, 16'h0000);
    send_item(OP_DRAIN, 3'd7, 8'hFF, 8'hFF, 16'hFFFF);

    // random phases with different idling
    for (int m = 0; m < 4; m++) begin
      idle_mode = m;
      random_items(PER_PHASE);
      hold_until_drained();
    end
    idle_mode = 0;

    $display("sent %0d items (report %0d, tick %0d, enqueue %0d, drain %0d)",
             sent, op_seen[OP_REPORT], op_seen[OP_TICK], op_seen[OP_ENQ],
             op_seen[OP_DRAIN]);
    $display("released %0d, handed back %0d, refused %0d, largest drain %0d, periods %0d",
             sb.n_released, sb.n_handback, sb.n_refused, sb.biggest_drain, sb.periods);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

@@ files.f @@
sv/gpct_pkg.sv
sv/gpct_ram.sv
sv/grace_period_callback_tracker_unit.sv
dv/tb.sv
